// ===== rtl/cfvc_pkg.sv =====
`timescale 1ns / 1ps

package cfvc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WARN_LEVEL     = 2'd0;
  localparam logic [1:0] CFG_DANGER_LEVEL   = 2'd1;
  localparam logic [1:0] CFG_POT_DEADBAND   = 2'd2;
  localparam logic [1:0] CFG_FAN_FULL_SPEED = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [5:0]  WARN_LEVEL_RESET     = 6'd25;
  localparam logic [5:0]  DANGER_LEVEL_RESET   = 6'd35;
  localparam logic [11:0] POT_DEADBAND_RESET   = 12'd50;
  localparam logic [9:0]  FAN_FULL_SPEED_RESET = 10'd800;

  // Temperature limits and map break points, in 1/256 degree.
  localparam logic signed [15:0] TEMP_MIN       = -16'sd2560;
  localparam logic signed [15:0] TEMP_MAX       = 16'sd15360;
  localparam logic signed [15:0] TEMP_RESET     = 16'sd6400;
  localparam logic signed [15:0] VENT_MAP_LOW   = 16'sd5120;
  localparam logic signed [15:0] FAN_MAP_LOW    = 16'sd6400;
  localparam logic signed [15:0] MAP_HIGH       = 16'sd10240;
  localparam logic [15:0]        VENT_SMOOTH_MAX = 16'd46080;

  // Reciprocal multipliers: floor(x / D) == (x * RECIP) >> SHIFT over the ranges used.
  localparam logic [16:0] RECIP_5         = 17'd52429;    // shift 18
  localparam logic [16:0] RECIP_FAN_COOL  = 17'd107375;   // x/625, shift 26
  localparam logic [12:0] RECIP_VENT_COOL = 13'd5992;     // x/175, shift 20
  localparam logic [22:0] RECIP_POT       = 23'd4195329;  // x/4095, shift 34
  localparam logic [17:0] RECIP_FAN_MAP   = 18'd223697;   // x/150, shift 25

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELAX,
    ST_TEMP,
    ST_MAP,
    ST_FINISH
  } cfvc_state_t;

  // Stage strobes from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic relax;
    logic temp;
    logic map;
    logic commit;
  } cfvc_cmd_t;

  typedef struct packed {
    logic [5:0]  warn_level;
    logic [5:0]  danger_level;
    logic [11:0] pot_deadband;
    logic [9:0]  fan_full_speed;
  } cfvc_cfg_t;

  typedef struct packed {
    logic signed [15:0] sensor_temp;
    logic               emergency_in;
    logic               toggle_request;
    logic signed [15:0] encoder_position;
    logic [11:0]        pot_level;
  } cfvc_item_t;

  typedef struct packed {
    logic signed [14:0] virtual_temp;
    logic [9:0]         fan_speed;
    logic [7:0]         vent_angle;
    logic               warn_flag;
    logic               danger_flag;
    logic               emergency_flag;
    logic               manual_active;
  } cfvc_result_t;

endpackage

// ===== rtl/cooling_fan_vent_controller.sv =====
`timescale 1ns / 1ps
// Channel    Direction  Width  Contents
// s_axis     in         48     one control tick: sensor, emergency, toggle, encoder, pot
// m_axis     out        40     one result per tick: temperature, fan, vent, flags
// cfg        in         12     register write: warn, danger, pot deadband, fan full speed
//
// Each tick passes through the relax, temperature, map and finish steps of the
// shared datapath, one after another, from acceptance to the next acceptance.
// A new tick is accepted in the finish cycle if the result register is free.
// The result register holds a finished result while the next tick is worked on;
// a stalled result register holds the finish step and so the input.
// Reset is synchronous; after it the block accepts a tick at once.

module cooling_fan_vent_controller
  import cfvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] sensor_temp, [16] emergency_in, [17] toggle_request,
  // [33:18] encoder_position, [45:34] pot_level, [47:46] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] virtual_temp, [24:15] fan_speed, [32:25] vent_angle, [33] warn_flag,
  // [34] danger_flag, [35] emergency_flag, [36] manual_active, [39:37] zero
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  cfvc_cmd_t    cmd;
  cfvc_cfg_t    cfg;
  cfvc_item_t   item;
  cfvc_result_t res;

  // Unpack the input transaction.
  assign item.sensor_temp      = s_axis_tdata[15:0];
  assign item.emergency_in     = s_axis_tdata[16];
  assign item.toggle_request   = s_axis_tdata[17];
  assign item.encoder_position = s_axis_tdata[33:18];
  assign item.pot_level        = s_axis_tdata[45:34];

  cfvc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  cfvc_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .cfg  (cfg),
    .item (item),
    .res  (res)
  );

  // Pack the result transaction.
  assign m_axis_tdata = {3'b000, res.manual_active, res.emergency_flag, res.danger_flag,
                         res.warn_flag, res.vent_angle, res.fan_speed, res.virtual_temp};

  // A commit never overwrites a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten while stalled");

  // Input capture happens exactly on an input transaction.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) == cmd.load)
    else $error("input capture out of step with handshake");

  // A commit always presents a result on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_axis_tvalid)
    else $error("committed result not presented");

  // A tick passes through its relax, temperature and map steps before it can commit.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !cmd.commit ##1 !cmd.commit ##1 !cmd.commit)
    else $error("tick committed too early");

endmodule

// ===== rtl/cfvc_cfg.sv =====
`timescale 1ns / 1ps

module cfvc_cfg
  import cfvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output cfvc_cfg_t   cfg
);

  // Register file, written one register per enabled cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_level     <= WARN_LEVEL_RESET;
      cfg.danger_level   <= DANGER_LEVEL_RESET;
      cfg.pot_deadband   <= POT_DEADBAND_RESET;
      cfg.fan_full_speed <= FAN_FULL_SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WARN_LEVEL:     cfg.warn_level     <= cfg_data[5:0];
        CFG_DANGER_LEVEL:   cfg.danger_level   <= cfg_data[5:0];
        CFG_POT_DEADBAND:   cfg.pot_deadband   <= cfg_data;
        CFG_FAN_FULL_SPEED: cfg.fan_full_speed <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cfvc_ctrl.sv =====
`timescale 1ns / 1ps

module cfvc_ctrl
  import cfvc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output cfvc_cmd_t cmd
);

  cfvc_state_t state, state_next;
  logic        out_valid_next;
  logic        can_commit;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // The result register may be loaded when empty or drained this cycle.
  assign can_commit = !out_valid || out_ready;

  // Next state and stage strobes.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RELAX;
        end
      end
      ST_RELAX: begin
        cmd.relax  = 1'b1;
        state_next = ST_TEMP;
      end
      ST_TEMP: begin
        cmd.temp   = 1'b1;
        state_next = ST_MAP;
      end
      ST_MAP: begin
        cmd.map    = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = ST_RELAX;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A result stays valid until taken; a commit refills it.
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== rtl/cfvc_datapath.sv =====
`timescale 1ns / 1ps

module cfvc_datapath
  import cfvc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfvc_cmd_t    cmd,
  input  cfvc_cfg_t    cfg,
  input  cfvc_item_t   item,
  output cfvc_result_t res
);

  // Controller state carried from tick to tick.
  logic signed [15:0] model_temp;
  logic               manual_mode;
  logic [9:0]         last_fan;
  logic [7:0]         last_vent;
  logic [7:0]         vent_base;
  logic [15:0]        encoder_reference;
  logic [15:0]        vent_smoothed;
  logic               entry_pending;

  // Captured input item.
  cfvc_item_t in_r;

  // Stage registers.
  logic [13:0]        rel_q;
  logic               rel_neg;
  logic [6:0]         fan_cool;
  logic [6:0]         vent_cool;
  logic [21:0]        pot_prod;
  logic [7:0]         enc_m;
  logic               enc_neg;
  logic signed [15:0] t_new;
  logic [9:0]         man_fan;
  logic [7:0]         vent_target;
  logic [7:0]         auto_vent;
  logic               fan_low;
  logic               fan_high;
  logic [17:0]        fan_prod;
  logic [15:0]        vs_cand;
  logic               warn_r;
  logic               danger_r;

  // ---------------- Relax stage ----------------
  logic signed [16:0] rl_diff;
  logic [16:0]        rl_mag;
  logic [33:0]        rl_prod;
  logic [32:0]        fc_prod;
  logic [26:0]        vc_prod;
  logic               enter_manual;
  logic [15:0]        enc_ref_eff;
  logic [15:0]        enc_d;
  logic signed [16:0] enc_n;
  logic signed [8:0]  enc_nc;
  logic [8:0]         enc_abs;
  logic [10:0]        enc_a6;
  logic [27:0]        enc_prod;

  // Relaxation step magnitude: |S - T| / 5, sign kept apart for truncation to zero.
  assign rl_diff = $signed({in_r.sensor_temp[15], in_r.sensor_temp})
                 - $signed({model_temp[15], model_temp});
  assign rl_mag  = rl_diff[16] ? 17'(-rl_diff) : 17'(rl_diff);
  assign rl_prod = 34'(rl_mag) * 34'(RECIP_5);

  // Cooling by the previous fan speed and vent angle.
  assign fc_prod = 33'({last_fan, 6'd0}) * 33'(RECIP_FAN_COOL);
  assign vc_prod = 27'({last_vent, 6'd0}) * 27'(RECIP_VENT_COOL);

  // Encoder offset scaled by 6/5; the offset is clamped first where the
  // final vent offset saturates anyway.
  assign enter_manual = in_r.toggle_request && !manual_mode;
  assign enc_ref_eff  = enter_manual ? in_r.encoder_position : encoder_reference;
  assign enc_d        = 16'(in_r.encoder_position - enc_ref_eff);
  assign enc_n        = $signed({enc_d[15], enc_d}) + 17'sd50;

  always_comb begin
    if (enc_n > 17'sd200) begin
      enc_nc = 9'sd200;
    end else if (enc_n < -17'sd200) begin
      enc_nc = -9'sd200;
    end else begin
      enc_nc = enc_n[8:0];
    end
  end

  assign enc_abs  = enc_nc[8] ? 9'(-enc_nc) : 9'(enc_nc);
  assign enc_a6   = 11'({enc_abs[7:0], 2'b00}) + 11'({enc_abs[7:0], 1'b0});
  assign enc_prod = 28'(enc_a6) * 28'(RECIP_5);

  // ---------------- Temperature stage ----------------
  logic signed [17:0] tp_rel;
  logic signed [17:0] tp_fc;
  logic signed [17:0] tp_vc;
  logic signed [17:0] tp_warm;
  logic signed [17:0] tp_sum;
  logic signed [15:0] tp_t;
  logic [44:0]        mf_prod;
  logic signed [9:0]  tp_m;
  logic signed [9:0]  tp_r;
  logic signed [9:0]  tp_rc;
  logic signed [10:0] tp_tgt;
  logic [7:0]         tp_tgt_c;

  assign tp_rel  = rel_neg ? -$signed({4'd0, rel_q}) : $signed({4'd0, rel_q});
  assign tp_fc   = (last_fan > 10'd40) ? $signed({11'd0, fan_cool}) : 18'sd0;
  assign tp_vc   = (last_vent > 8'd60) ? $signed({11'd0, vent_cool}) : 18'sd0;
  assign tp_warm = (last_fan < 10'd30 && last_vent < 8'd20) ? 18'sd4 : 18'sd0;
  assign tp_sum  = $signed({{2{model_temp[15]}}, model_temp}) + tp_rel - tp_fc - tp_vc
                 + tp_warm;

  // Clamp the modelled temperature to its range.
  always_comb begin
    if (tp_sum < $signed({{2{TEMP_MIN[15]}}, TEMP_MIN})) begin
      tp_t = TEMP_MIN;
    end else if (tp_sum > $signed({{2{TEMP_MAX[15]}}, TEMP_MAX})) begin
      tp_t = TEMP_MAX;
    end else begin
      tp_t = tp_sum[15:0];
    end
  end

  // Manual fan: pot * full speed / 4095.
  assign mf_prod = 45'(pot_prod) * 45'(RECIP_POT);

  // Manual vent target: offset with saturation and a small dead zone.
  assign tp_m = enc_neg ? -$signed({2'b00, enc_m}) : $signed({2'b00, enc_m});
  assign tp_r = tp_m - 10'sd60;

  always_comb begin
    if (tp_r > 10'sd60) begin
      tp_rc = 10'sd60;
    end else if (tp_r < -10'sd60) begin
      tp_rc = -10'sd60;
    end else if (tp_r > -10'sd3 && tp_r < 10'sd3) begin
      tp_rc = 10'sd0;
    end else begin
      tp_rc = tp_r;
    end
  end

  assign tp_tgt = $signed({3'b000, vent_base}) + $signed({tp_rc[9], tp_rc});

  always_comb begin
    if (tp_tgt < 11'sd0) begin
      tp_tgt_c = 8'd0;
    end else if (tp_tgt > 11'sd180) begin
      tp_tgt_c = 8'd180;
    end else begin
      tp_tgt_c = tp_tgt[7:0];
    end
  end

  // ---------------- Map stage ----------------
  logic [13:0]        mp_vofs;
  logic [17:0]        mp_v15;
  logic [7:0]         mp_vent;
  logic [17:0]        mp_t10;
  logic [9:0]         mp_x;
  logic [7:0]         mp_xm;
  logic signed [16:0] mp_vsd;
  logic signed [16:0] mp_vsq;
  logic signed [17:0] mp_vss;
  logic [15:0]        mp_vsc;
  logic signed [15:0] mp_warn_t;
  logic signed [15:0] mp_danger_t;

  // Auto vent: linear from 10 to 160 degrees between 20 and 40 degrees.
  assign mp_vofs = 14'(t_new[13:0] - VENT_MAP_LOW[13:0]);
  assign mp_v15  = 18'(mp_vofs) * 18'd15;

  always_comb begin
    if (t_new < VENT_MAP_LOW) begin
      mp_vent = 8'd10;
    end else if (t_new > MAP_HIGH) begin
      mp_vent = 8'd160;
    end else begin
      mp_vent = 8'd10 + mp_v15[16:9];
    end
  end

  // Auto fan numerator: (floor(T*10/256) - 250) * full speed.
  assign mp_t10 = 18'(t_new[13:0]) * 18'd10;
  assign mp_x   = mp_t10[17:8];
  assign mp_xm  = 8'(mp_x - 10'd250);

  // Vent smoothing: a quarter of the distance, truncated toward zero.
  assign mp_vsd = $signed({1'b0, vent_target, 8'd0}) - $signed({1'b0, vent_smoothed});
  assign mp_vsq = (mp_vsd + (mp_vsd[16] ? 17'sd3 : 17'sd0)) >>> 2;
  assign mp_vss = $signed({2'b00, vent_smoothed}) + $signed({mp_vsq[16], mp_vsq});

  always_comb begin
    if (mp_vss < 18'sd0) begin
      mp_vsc = 16'd0;
    end else if (mp_vss > $signed({2'b00, VENT_SMOOTH_MAX})) begin
      mp_vsc = VENT_SMOOTH_MAX;
    end else begin
      mp_vsc = mp_vss[15:0];
    end
  end

  assign mp_warn_t   = $signed({2'b00, cfg.warn_level, 8'd0});
  assign mp_danger_t = $signed({2'b00, cfg.danger_level, 8'd0});

  // ---------------- Finish stage ----------------
  logic [35:0]  fn_prod;
  logic [9:0]   fn_auto_fan;
  logic [9:0]   fn_fan;
  logic [7:0]   fn_vent;
  logic         fn_warn;
  logic         fn_danger;
  logic [15:0]  fn_vs;
  logic         fn_pending;

  assign fn_prod = 36'(fan_prod) * 36'(RECIP_FAN_MAP);

  always_comb begin
    if (fan_low) begin
      fn_auto_fan = 10'd0;
    end else if (fan_high) begin
      fn_auto_fan = cfg.fan_full_speed;
    end else begin
      fn_auto_fan = fn_prod[34:25];
    end
  end

  // Select between emergency, auto and manual results.
  always_comb begin
    fn_fan     = 10'd0;
    fn_vent    = 8'd0;
    fn_warn    = 1'b0;
    fn_danger  = 1'b1;
    fn_vs      = vent_smoothed;
    fn_pending = entry_pending;
    if (!in_r.emergency_in) begin
      fn_warn   = warn_r;
      fn_danger = danger_r;
      if (!manual_mode) begin
        fn_fan  = fn_auto_fan;
        fn_vent = auto_vent;
      end else begin
        fn_fan = man_fan;
        if (entry_pending) begin
          fn_vent    = vent_base;
          fn_vs      = {vent_base, 8'd0};
          fn_pending = 1'b0;
        end else begin
          fn_vent = vs_cand[15:8];
          fn_vs   = vs_cand;
        end
      end
    end
  end

  // Input capture and stage registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= item;
    end
    if (cmd.relax) begin
      rel_q     <= rl_prod[31:18];
      rel_neg   <= rl_diff[16];
      fan_cool  <= fc_prod[32:26];
      vent_cool <= vc_prod[26:20];
      pot_prod  <= 22'(in_r.pot_level) * 22'(cfg.fan_full_speed);
      enc_m     <= enc_prod[25:18];
      enc_neg   <= enc_nc[8];
    end
    if (cmd.temp) begin
      t_new       <= tp_t;
      man_fan     <= (in_r.pot_level < cfg.pot_deadband) ? 10'd0 : mf_prod[43:34];
      vent_target <= tp_tgt_c;
    end
    if (cmd.map) begin
      auto_vent <= mp_vent;
      fan_low   <= t_new < FAN_MAP_LOW;
      fan_high  <= t_new > MAP_HIGH;
      fan_prod  <= 18'(mp_xm) * 18'(cfg.fan_full_speed);
      vs_cand   <= mp_vsc;
      danger_r  <= t_new >= mp_danger_t;
      warn_r    <= (t_new >= mp_warn_t) && (t_new < mp_danger_t);
    end
    if (cmd.commit) begin
      res.virtual_temp   <= t_new[14:0];
      res.fan_speed      <= fn_fan;
      res.vent_angle     <= fn_vent;
      res.warn_flag      <= fn_warn;
      res.danger_flag    <= fn_danger;
      res.emergency_flag <= in_r.emergency_in;
      res.manual_active  <= manual_mode;
    end
  end

  // Tick state: mode toggle in the relax step, model update at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      model_temp        <= TEMP_RESET;
      manual_mode       <= 1'b0;
      last_fan          <= 10'd0;
      last_vent         <= 8'd0;
      vent_base         <= 8'd0;
      encoder_reference <= 16'd0;
      vent_smoothed     <= 16'd0;
      entry_pending     <= 1'b0;
    end else begin
      if (cmd.relax && in_r.toggle_request) begin
        manual_mode <= !manual_mode;
        if (enter_manual) begin
          vent_base         <= last_vent;
          encoder_reference <= in_r.encoder_position;
          vent_smoothed     <= {last_vent, 8'd0};
          entry_pending     <= 1'b1;
        end
      end
      if (cmd.commit) begin
        model_temp    <= t_new;
        last_fan      <= fn_fan;
        last_vent     <= fn_vent;
        vent_smoothed <= fn_vs;
        entry_pending <= fn_pending;
      end
    end
  end

endmodule

// ===== bench/cooling_fan_vent_controller_test.sv =====
`timescale 1ns / 1ps

module cooling_fan_vent_controller_test;
  import cfvc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_TICKS = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [15:0] sensor_temp, [16] emergency_in, [17] toggle_request,
  // [33:18] encoder_position, [45:34] pot_level, [47:46] zero
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [14:0] virtual_temp, [24:15] fan_speed, [32:25] vent_angle, [33] warn_flag,
  // [34] danger_flag, [35] emergency_flag, [36] manual_active, [39:37] zero
  logic [39:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_WARN_LEVEL;
  logic [11:0] cfg_data = '0;

  // Controller state as the bench tracks it.
  int                 ctl_temp;
  logic               ctl_manual;
  int                 prev_fan;
  int                 prev_vent;
  int                 manual_base;
  logic signed [15:0] enc_origin;
  int                 vent_filter;
  logic               first_manual;

  // Register copies.
  int lvl_warn;
  int lvl_danger;
  int pot_floor;
  int fan_full;

  cfvc_result_t predicted_outputs[$];

  int  err_count = 0;
  int  ticks_sent = 0;
  int  results_seen = 0;
  int  manual_seen = 0;
  int  emergency_seen = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  sender_idle_en = 1'b1;
  bit  receiver_stall_en = 1'b1;

  // Stimulus generator state.
  int                 sensor_walk = 6400;
  logic signed [15:0] enc_walk = '0;
  logic               emg_latched = 1'b0;

  cooling_fan_vent_controller dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, predicted_outputs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Return the bench's controller model and register copies to their reset state.
  task automatic reset_control_model();
    ctl_temp     = int'(TEMP_RESET);
    ctl_manual   = 1'b0;
    prev_fan     = 0;
    prev_vent    = 0;
    manual_base  = 0;
    enc_origin   = '0;
    vent_filter  = 0;
    first_manual = 1'b0;
    lvl_warn     = int'(WARN_LEVEL_RESET);
    lvl_danger   = int'(DANGER_LEVEL_RESET);
    pot_floor    = int'(POT_DEADBAND_RESET);
    fan_full     = int'(FAN_FULL_SPEED_RESET);
  endtask

  // Work out one control tick: temperature model, then fan and vent commands.
  function automatic cfvc_result_t model_control_tick(input cfvc_item_t tk);
    int                 s;
    int                 t;
    int                 fan;
    int                 vent;
    int                 x;
    int                 d;
    int                 r;
    int                 tgt;
    logic signed [15:0] dwrap;
    logic               warn;
    logic               danger;
    cfvc_result_t       res;
    // A toggle acts first, even during an emergency; entering manual snapshots the vent.
    if (tk.toggle_request) begin
      if (!ctl_manual) begin
        manual_base  = prev_vent;
        enc_origin   = tk.encoder_position;
        vent_filter  = prev_vent * 256;
        first_manual = 1'b1;
      end
      ctl_manual = !ctl_manual;
    end

    // Relax toward the sensor, cool by last commands, warm when both are low.
    s = int'($signed(tk.sensor_temp));
    t = ctl_temp;
    t = t + (s - t) / 5;
    if (prev_fan > 40) t = t - prev_fan * 256 / 2500;
    if (prev_vent > 60) t = t - prev_vent * 256 / 700;
    if (prev_fan < 30 && prev_vent < 20) t = t + 4;
    if (t < -2560) t = -2560;
    if (t > 15360) t = 15360;
    ctl_temp = t;

    if (tk.emergency_in) begin
      fan    = 0;
      vent   = 0;
      danger = 1'b1;
      warn   = 1'b0;
    end else begin
      if (!ctl_manual) begin
        // Auto mode: linear maps between the break points.
        if (t < 20 * 256) vent = 10;
        else if (t > 40 * 256) vent = 160;
        else vent = 10 + (t - 5120) * 15 / 512;
        if (t < 25 * 256) fan = 0;
        else if (t > 40 * 256) fan = fan_full;
        else begin
          x   = t * 10 / 256;
          fan = (x - 250) * fan_full / 150;
        end
      end else begin
        // Manual mode: pot sets the fan, encoder offset steers the vent.
        fan = (tk.pot_level < pot_floor) ? 0 : int'(tk.pot_level) * fan_full / 4095;
        if (first_manual) begin
          vent_filter  = manual_base * 256;
          vent         = manual_base;
          first_manual = 1'b0;
        end else begin
          dwrap = tk.encoder_position - enc_origin;
          d = int'(dwrap);
          r = (d + 50) * 120 / 100 - 60;
          if (r < -60) r = -60;
          if (r > 60) r = 60;
          if (r > -3 && r < 3) r = 0;
          tgt = manual_base + r;
          if (tgt < 0) tgt = 0;
          if (tgt > 180) tgt = 180;
          vent_filter = vent_filter + (tgt * 256 - vent_filter) / 4;
          if (vent_filter < 0) vent_filter = 0;
          if (vent_filter > 180 * 256) vent_filter = 180 * 256;
          vent = vent_filter / 256;
        end
      end
      danger = (t >= lvl_danger * 256);
      warn   = (t >= lvl_warn * 256) && (t < lvl_danger * 256);
    end

    prev_fan  = fan & 1023;
    prev_vent = vent & 255;

    res.virtual_temp   = t[14:0];
    res.fan_speed      = fan[9:0];
    res.vent_angle     = vent[7:0];
    res.warn_flag      = warn;
    res.danger_flag    = danger;
    res.emergency_flag = tk.emergency_in;
    res.manual_active  = ctl_manual;
    return res;
  endfunction

  // Send one control tick, with an occasional idle burst before it.
  task automatic send_tick(input cfvc_item_t tk);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, tk.pot_level, tk.encoder_position, tk.toggle_request,
                      tk.emergency_in, tk.sensor_temp};
    do @(posedge clk); while (!s_axis_tready);
    predicted_outputs.push_back(model_control_tick(tk));
    ticks_sent++;
  endtask

  task automatic send_fields(input int sensor, input bit emg, input bit tog,
                             input int enc, input int pot);
    cfvc_item_t tk;
    tk.sensor_temp      = sensor[15:0];
    tk.emergency_in     = emg;
    tk.toggle_request   = tog;
    tk.encoder_position = enc[15:0];
    tk.pot_level        = pot[11:0];
    send_tick(tk);
  endtask

  // Random tick: drifting sensor, latched emergency, encoder walk, rare toggles.
  function automatic cfvc_item_t random_tick();
    cfvc_item_t tk;
    int         pot;
    if ($urandom_range(0, 19) == 0) sensor_walk = int'($urandom_range(0, 30720)) - 10240;
    else sensor_walk = sensor_walk + int'($urandom_range(0, 1200)) - 600;
    if (sensor_walk < -10240) sensor_walk = -10240;
    if (sensor_walk > 20480) sensor_walk = 20480;
    if ($urandom_range(0, 29) == 0) emg_latched = !emg_latched;
    if ($urandom_range(0, 63) == 0) enc_walk = 16'($urandom);
    else if ($urandom_range(0, 15) == 0)
      enc_walk = 16'(enc_origin + int'($urandom_range(0, 160)) - 80);
    else enc_walk = 16'(enc_walk + int'($urandom_range(0, 60)) - 30);
    if ($urandom_range(0, 7) == 0) begin
      pot = pot_floor + int'($urandom_range(0, 4)) - 2;
      if (pot < 0) pot = 0;
      if (pot > 4095) pot = 4095;
    end else begin
      pot = $urandom_range(0, 4095);
    end
    tk.sensor_temp      = sensor_walk[15:0];
    tk.emergency_in     = emg_latched;
    tk.toggle_request   = ($urandom_range(0, 11) == 0);
    tk.encoder_position = enc_walk;
    tk.pot_level        = pot[11:0];
    return tk;
  endfunction

  // Hold the sender off until every result is back and the block has settled.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[11:0];
    @(posedge clk);
  endtask

  // Write all four registers while the block is idle.
  task automatic apply_config(input int warn_deg, input int danger_deg,
                              input int deadband, input int full_speed);
    put_reg(CFG_WARN_LEVEL, warn_deg);
    put_reg(CFG_DANGER_LEVEL, danger_deg);
    put_reg(CFG_POT_DEADBAND, deadband);
    put_reg(CFG_FAN_FULL_SPEED, full_speed);
    cfg_we     <= 1'b0;
    lvl_warn   = warn_deg;
    lvl_danger = danger_deg;
    pot_floor  = deadband;
    fan_full   = full_speed;
    settings_used++;
  endtask

  task automatic run_random_ticks(input int count);
    repeat (count) send_tick(random_tick());
  endtask

  // Reset values, field extremes, mode entry and exit, emergency, encoder wrap.
  task automatic test_directed_reset_values();
    repeat (4) send_fields(20480, 0, 0, 0, 4095);
    // Enter manual from a hot auto state, so the vent base is high.
    send_fields(20480, 0, 1, 32767, 4095);
    // Encoder wraps: small offset in the dead zone, then large offsets both ways.
    send_fields(20480, 0, 0, -32768, 49);
    send_fields(0, 0, 0, -32569, 50);
    send_fields(0, 0, 0, 32567, 0);
    send_fields(0, 0, 0, -32766, 1023);
    // Emergency in manual, leave and re-enter manual while it lasts.
    send_fields(0, 1, 0, 32767, 4095);
    send_fields(0, 1, 1, 32767, 4095);
    send_fields(0, 1, 1, 0, 4095);
    // The first manual tick comes after the emergency clears.
    send_fields(0, 0, 0, 0, 4095);
    send_fields(0, 0, 0, -2, 2048);
    // Back to auto and down to the low clamp.
    send_fields(-10240, 0, 1, 0, 0);
    repeat (5) send_fields(-10240, 0, 0, 0, 0);
    send_fields(0, 0, 0, 0, 0);
    send_fields(10240, 0, 0, 0, 0);
  endtask

  // Defaults written back explicitly, then levels of 0 and 60 and both extremes of the other registers.
  task automatic test_register_extremes();
    drain_results();
    apply_config(int'(WARN_LEVEL_RESET), int'(DANGER_LEVEL_RESET), int'(POT_DEADBAND_RESET),
                 int'(FAN_FULL_SPEED_RESET));
    run_random_ticks(PHASE_TICKS);
    drain_results();
    apply_config(0, 60, 0, 1023);
    run_random_ticks(PHASE_TICKS);
    drain_results();
    // Warn above danger: warning must stay low.
    apply_config(60, 0, 4095, 0);
    run_random_ticks(PHASE_TICKS);
  endtask

  task automatic test_random_registers();
    int deadband;
    repeat (4) begin
      drain_results();
      deadband = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 200);
      apply_config($urandom_range(0, 60), $urandom_range(0, 60), deadband,
                   $urandom_range(0, 1023));
      run_random_ticks(PHASE_TICKS);
    end
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_steady_stream();
    drain_results();
    sender_idle_en    = 1'b0;
    receiver_stall_en = 1'b0;
    apply_config(30, 38, 100, 900);
    run_random_ticks(230);
  endtask

  // Receiver side: random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (receiver_stall_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void check_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      err_count++;
    end
  endfunction

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    cfvc_result_t got;
    cfvc_result_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got.virtual_temp   = m_axis_tdata[14:0];
      got.fan_speed      = m_axis_tdata[24:15];
      got.vent_angle     = m_axis_tdata[32:25];
      got.warn_flag      = m_axis_tdata[33];
      got.danger_flag    = m_axis_tdata[34];
      got.emergency_flag = m_axis_tdata[35];
      got.manual_active  = m_axis_tdata[36];
      if (predicted_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        err_count++;
      end else begin
        want = predicted_outputs.pop_front();
        results_seen++;
        if (want.manual_active) manual_seen++;
        if (want.emergency_flag) emergency_seen++;
        check_field("virtual_temp", int'($signed(want.virtual_temp)),
                    int'($signed(got.virtual_temp)));
        check_field("fan_speed", int'(want.fan_speed), int'(got.fan_speed));
        check_field("vent_angle", int'(want.vent_angle), int'(got.vent_angle));
        check_field("warn_flag", int'(want.warn_flag), int'(got.warn_flag));
        check_field("danger_flag", int'(want.danger_flag), int'(got.danger_flag));
        check_field("emergency_flag", int'(want.emergency_flag), int'(got.emergency_flag));
        check_field("manual_active", int'(want.manual_active), int'(got.manual_active));
      end
    end
  end

  initial begin
    reset_control_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_reset_values();
    test_register_extremes();
    test_random_registers();
    test_steady_stream();

    drain_results();
    repeat (16) @(posedge clk);
    if (predicted_outputs.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, predicted_outputs.size());
      err_count++;
    end
    $display("Run covered %0d control ticks under %0d register settings, %0d results checked.",
             ticks_sent, settings_used + 1, results_seen);
    $display("Of those, %0d came in manual mode and %0d during emergency.",
             manual_seen, emergency_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
